/* design/ccq_pkg.sv */
package ccq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_DISCARD = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  localparam logic [2:0] KIND_EFFECT     = 3'd2;
  localparam logic [2:0] KIND_RGB        = 3'd3;
  localparam logic [2:0] KIND_BRIGHTNESS = 3'd4;
  localparam logic [2:0] KIND_RECONCILE  = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  cmd_type;
    logic        allow_coalesce;
    logic [31:0] cmd_generation;
    logic [7:0]  cmd_length;
    logic [63:0] cmd_payload;
    logic [31:0] ref_generation;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  out_type;
    logic [31:0] out_id;
    logic [31:0] out_generation;
    logic [7:0]  out_length;
    logic [63:0] out_payload;
    logic [4:0]  discarded_count;
    logic [4:0]  queue_depth;
    logic [31:0] coalesce_total;
  } res_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ident;
    logic [31:0] gen;
    logic [7:0]  len;
    logic [63:0] data;
  } entry_t;

  // per-cycle write command from the sequencer to every cell
  typedef struct packed {
    logic   write;   // cell at sel takes wentry
    entry_t wentry;
  } cell_ctl_t;

  function automatic logic replaceable(input logic [2:0] k);
    return (k == KIND_EFFECT) || (k == KIND_RGB) || (k == KIND_BRIGHTNESS) ||
           (k == KIND_RECONCILE);
  endfunction

endpackage

/* design/ccq_cell.sv */
module ccq_cell (
  input  logic               clk_i,
  input  ccq_pkg::cell_ctl_t ctl_i,
  input  logic               sel_i,
  input  logic               shift_i,
  input  ccq_pkg::entry_t    next_i,
  output ccq_pkg::entry_t    entry_o
);

  ccq_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.write && sel_i) begin
      entry_q <= ctl_i.wentry;
    end else if (shift_i) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

/* design/coalescing_command_queue.sv */
// Push and clear: done_o strobes in ST_DONE, which follows ST_EXEC after start is taken.
// Pop and discard-older examine one slot per cycle in ST_WALK, then go to ST_DONE
// (pop stops at the first live entry).
// busy is high until the strobe cycle ends; no new request is taken before then.
// The strobe lasts one cycle; the receiver cannot stall.
// Reset (async, active low) empties the queue, sets next id 1, clears coalesce count.
module coalescing_command_queue #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int MAX_PAYLOAD_LEN = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ccq_pkg::cmd_t cmd_i,
  output logic          done_o,
  output ccq_pkg::res_t res_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  ccq_pkg::cmd_t   cmd_q;
  ccq_pkg::res_t   res_q, res_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   step_q, step_d;
  logic [CW-1:0]   keep_q, keep_d;
  logic [CW-1:0]   drop_q, drop_d;
  logic            found_q, found_d;
  logic [31:0]     next_id_q, next_id_d;
  logic [31:0]     coal_q, coal_d;
  logic            done_q;

  ccq_pkg::cell_ctl_t ctl;
  logic [QUEUE_DEPTH-1:0] sel;
  logic [QUEUE_DEPTH-1:0] shen;
  ccq_pkg::entry_t ent [QUEUE_DEPTH];
  ccq_pkg::entry_t cur;

  // chain shifts toward index 0; cells at or above the removal point take their neighbor
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    ccq_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .sel_i  (sel[g]),
      .shift_i(shen[g]),
      .next_i (ent[(g + 1) % QUEUE_DEPTH]),
      .entry_o(ent[g])
    );
  end

  // entry under examination; kept entries stay below keep_q
  assign cur = ent[keep_q[IW-1:0]];

  // newest matching slot for coalescing
  logic          hit;
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((CW'(i) < count_q) && (ent[i].kind == cmd_q.cmd_type)) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  logic stale;
  logic [31:0] nid;
  always_comb begin
    if (cmd_q.req_type == ccq_pkg::REQ_POP) begin
      stale = (cur.gen != '0) && (cmd_q.ref_generation != '0) &&
              (cur.gen < cmd_q.ref_generation);
    end else begin
      stale = (cur.gen != '0) && (cur.gen < cmd_q.ref_generation);
    end
    nid = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    count_d   = count_q;
    step_d    = step_q;
    keep_d    = keep_q;
    drop_d    = drop_q;
    found_d   = found_q;
    next_id_d = next_id_q;
    coal_d    = coal_q;
    ctl       = '0;
    sel       = '0;
    shen      = '0;
    ctl.wentry = '{kind: cmd_q.cmd_type, ident: next_id_q, gen: cmd_q.cmd_generation,
                   len: cmd_q.cmd_length, data: cmd_q.cmd_payload};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d = '0;
        step_d = '0;
        keep_d = '0;
        drop_d = '0;
        found_d = 1'b0;
        state_d = ST_DONE;
        case (cmd_q.req_type)
          ccq_pkg::REQ_PUSH: begin
            if (cmd_q.cmd_length <= 8'(MAX_PAYLOAD_LEN)) begin
              next_id_d = nid;
              if (cmd_q.allow_coalesce && ccq_pkg::replaceable(cmd_q.cmd_type) && hit) begin
                ctl.write = 1'b1;
                sel[hit_idx] = 1'b1;
                coal_d = coal_q + 32'd1;
                res_d.ok = 1'b1;
              end else if (count_q < CW'(QUEUE_DEPTH)) begin
                ctl.write = 1'b1;
                sel[count_q[IW-1:0]] = 1'b1;
                count_d = count_q + CW'(1);
                res_d.ok = 1'b1;
              end
            end
          end
          ccq_pkg::REQ_CLEAR: count_d = '0;
          default: state_d = ST_WALK;
        endcase
      end
      ST_WALK: begin
        // one slot per cycle; a removed entry is closed up by the cells above it
        if ((step_q < count_q) && !found_q) begin
          step_d = step_q + CW'(1);
          if (stale) begin
            drop_d = drop_q + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              shen[i] = (CW'(i) >= keep_q);
            end
          end else if (cmd_q.req_type == ccq_pkg::REQ_POP) begin
            found_d = 1'b1;
            shen = '1;
            res_d.ok = 1'b1;
            res_d.out_type = cur.kind;
            res_d.out_id = cur.ident;
            res_d.out_generation = cur.gen;
            res_d.out_length = cur.len;
            res_d.out_payload = cur.data;
          end else begin
            keep_d = keep_q + CW'(1);
          end
        end else begin
          count_d = count_q - drop_q - CW'(found_q);
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    res_d.discarded_count = 5'(drop_d);
    res_d.queue_depth = 5'(count_d);
    res_d.coalesce_total = coal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      next_id_q <= 32'd1;
      coal_q    <= '0;
      done_q    <= 1'b0;
      step_q    <= '0;
      keep_q    <= '0;
      drop_q    <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      coal_q    <= coal_d;
      done_q    <= (state_q != ST_IDLE) && (state_d == ST_DONE);
      step_q    <= step_d;
      keep_q    <= keep_d;
      drop_q    <= drop_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* tb/sv/ccq_checker.sv */
module ccq_checker #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int MAX_PAYLOAD_LEN = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  ccq_pkg::cmd_t cmd_i,
  input  logic          done_o,
  input  ccq_pkg::res_t res_o,
  output int            fail_count,
  output int            pending
);

  ccq_pkg::entry_t q_model[$];
  logic [31:0]     id_next;
  logic [31:0]     coal_cnt;
  ccq_pkg::res_t   expected_results[$];

  assign pending = expected_results.size();

  function automatic logic is_stale_pop(logic [31:0] g, logic [31:0] r);
    return (g != 0) && (r != 0) && (g < r);
  endfunction

  task automatic predict_request(input ccq_pkg::cmd_t c);
    ccq_pkg::res_t   r;
    ccq_pkg::entry_t e;
    logic            hit;
    int              k;
    int              n;
    r = '0;
    hit = 1'b0;
    case (ccq_pkg::req_e'(c.req_type))
      ccq_pkg::REQ_PUSH: begin
        if (c.cmd_length <= MAX_PAYLOAD_LEN) begin
          e = '{c.cmd_type, id_next, c.cmd_generation, c.cmd_length, c.cmd_payload};
          id_next = id_next + 32'd1;
          if (id_next == 32'd0) id_next = 32'd1;
          if (c.allow_coalesce && ccq_pkg::replaceable(c.cmd_type)) begin
            for (int i = q_model.size() - 1; i >= 0 && !hit; i--) begin
              if (q_model[i].kind == c.cmd_type) begin
                q_model[i] = e;
                coal_cnt = coal_cnt + 32'd1;
                hit = 1'b1;
              end
            end
          end
          if (!hit && q_model.size() < QUEUE_DEPTH) begin
            q_model.push_back(e);
            hit = 1'b1;
          end
          r.ok = hit;
        end
      end
      ccq_pkg::REQ_POP: begin
        k = 0;
        while (q_model.size() > 0 && is_stale_pop(q_model[0].gen, c.ref_generation)) begin
          void'(q_model.pop_front());
          k++;
        end
        if (q_model.size() > 0) begin
          e = q_model.pop_front();
          r.ok = 1'b1;
          r.out_type = e.kind;
          r.out_id = e.ident;
          r.out_generation = e.gen;
          r.out_length = e.len;
          r.out_payload = e.data;
        end
        r.discarded_count = k[4:0];
      end
      ccq_pkg::REQ_DISCARD: begin
        n = q_model.size();
        for (int i = n - 1; i >= 0; i--)
          if (q_model[i].gen != 0 && q_model[i].gen < c.ref_generation) q_model.delete(i);
        k = n - q_model.size();
        r.discarded_count = k[4:0];
      end
      default: q_model.delete();
    endcase
    r.queue_depth = 5'(q_model.size());
    r.coalesce_total = coal_cnt;
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ccq_pkg::res_t x;
    if (!rst_ni) begin
      q_model.delete();
      expected_results.delete();
      id_next = 32'd1;
      coal_cnt = '0;
      fail_count = 0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", res_o);
        end else begin
          x = expected_results.pop_front();
          if (res_o !== x) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch exp %h got %h", x, res_o);
          end
        end
      end
      if (start && !busy) predict_request(cmd_i);
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  ccq_pkg::cmd_t cmd_i = '0;
  logic          done_o;
  ccq_pkg::res_t res_o;
  int            fail_count;
  int            pending;
  int            cycles = 0;

  always #5 clk_i = ~clk_i;

  coalescing_command_queue dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .res_o
  );

  ccq_checker chk (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .res_o, .fail_count, .pending
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // start stays high after the beat is taken; the caller lowers it before idling
  task automatic issue(input ccq_pkg::cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic ccq_pkg::cmd_t make_req(ccq_pkg::req_e rq, logic [2:0] kind, logic co,
                                             logic [31:0] g, logic [7:0] len,
                                             logic [31:0] rg);
    ccq_pkg::cmd_t c;
    c.req_type = rq;
    c.cmd_type = kind;
    c.allow_coalesce = co;
    c.cmd_generation = g;
    c.cmd_length = len;
    c.cmd_payload = {$urandom, $urandom};
    c.ref_generation = rg;
    return c;
  endfunction

  function automatic logic [31:0] rand_gen();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic ccq_pkg::cmd_t rand_req();
    int            p;
    ccq_pkg::req_e rq;
    p = $urandom_range(0, 99);
    rq = p < 55 ? ccq_pkg::REQ_PUSH : p < 85 ? ccq_pkg::REQ_POP :
         p < 96 ? ccq_pkg::REQ_DISCARD : ccq_pkg::REQ_CLEAR;
    return make_req(rq, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand_gen(),
                    8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
                       $urandom_range(0, 8)),
                    rand_gen());
  endfunction

  initial begin
    ccq_pkg::cmd_t c;
    int            gap;
    bit            paused;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    issue(make_req(ccq_pkg::REQ_POP, 0, 0, 0, 0, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, 1, 0, 5, 9, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, 1, 0, 5, 255, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, 7, 1, 0, 8, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_RGB, 1, 3, 0, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_RGB, 1, 4, 1, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_EFFECT, 1, 2, 2, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_BRIGHTNESS, 1, 32'hFFFF_FFFF, 3, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_RECONCILE, 1, 1, 4, 0));
    issue(make_req(ccq_pkg::REQ_POP, 0, 0, 0, 0, 0));
    issue(make_req(ccq_pkg::REQ_POP, 0, 0, 0, 0, 32'hFFFF_FFFF));
    issue(make_req(ccq_pkg::REQ_DISCARD, 0, 0, 0, 0, 3));
    for (int i = 0; i < 17; i++) issue(make_req(ccq_pkg::REQ_PUSH, 5, 0, i, 8, 0));
    issue(make_req(ccq_pkg::REQ_PUSH, ccq_pkg::KIND_EFFECT, 1, 9, 7, 0));
    issue(make_req(ccq_pkg::REQ_DISCARD, 0, 0, 0, 0, 32'hFFFF_FFFF));
    issue(make_req(ccq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
    issue(make_req(ccq_pkg::REQ_POP, 0, 0, 0, 0, 5));
    for (int n = 0; n < 1000;) begin
      for (int b = $urandom_range(1, 20); b > 0; b--, n++) begin
        c = rand_req();
        issue(c);
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      if (!paused && n > 500) begin
        paused = 1'b1;
        start <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end else if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
